FILE: src/voxel_ray_traversal_3d_top_defines.svh
// ----------------------------------------------------------------------------
// Voxel ray traversal assertion macros
// Shared property templates for the port-level checker of the traversal block.
// ----------------------------------------------------------------------------
`ifndef VOXEL_RAY_TRAVERSAL_3D_TOP_DEFINES_SVH
`define VOXEL_RAY_TRAVERSAL_3D_TOP_DEFINES_SVH

// Same-cycle implication, ignored while reset is asserted.
`define VRT_ASSERT_SAME(lbl, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error("voxel traversal check failed");

// Next-cycle implication, ignored while reset is asserted.
`define VRT_ASSERT_NEXT(lbl, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error("voxel traversal check failed");

// State that must hold in the cycle after a reset edge.
`define VRT_ASSERT_RESET(lbl, cons) \
  lbl: assert property (@(posedge clk) (!rst_n) |=> (cons)) \
    else $error("voxel traversal reset check failed");

`endif

FILE: src/vrt_pkg.sv
// ----------------------------------------------------------------------------
// Voxel ray traversal package
// Shared constants, register indexes, state encoding and status types.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

package vrt_pkg;

  // Default geometry of the block.
  localparam int MAX_SPAN     = 63;
  localparam int COORD_BITS   = 16;
  localparam int LIMIT_BITS   = 16;
  localparam int CFG_IDX_BITS = 8;

  // Configuration register indexes.
  localparam logic [CFG_IDX_BITS-1:0] CFG_SENSOR_X  = CFG_IDX_BITS'(0);
  localparam logic [CFG_IDX_BITS-1:0] CFG_SENSOR_Y  = CFG_IDX_BITS'(1);
  localparam logic [CFG_IDX_BITS-1:0] CFG_SENSOR_Z  = CFG_IDX_BITS'(2);
  localparam logic [CFG_IDX_BITS-1:0] CFG_RANGE_SQ  = CFG_IDX_BITS'(3);

  // Axis selectors for the shared unit.
  localparam logic [1:0] AX_X = 2'd0;
  localparam logic [1:0] AX_Z = 2'd2;

  // Sequencer states.
  typedef enum logic [2:0] {
    ST_IDLE,
    ST_SETUP,
    ST_INIT,
    ST_STEP,
    ST_EMIT,
    ST_FLUSH
  } vrt_state_t;

  // Status of the axis unit in setup mode.
  typedef struct packed {
    logic over;     // axis difference exceeds the walkable span
    logic dir_pos;  // target lies on the positive side of the sensor
  } vrt_flags_t;

endpackage

`default_nettype wire

FILE: src/vrt_in_if.sv
// ----------------------------------------------------------------------------
// Target request channel
// Valid/ready channel carrying one target voxel per request.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

interface vrt_in_if #(
  parameter int COORD_BITS = vrt_pkg::COORD_BITS
);
  logic                         valid;
  logic                         ready;
  logic signed [COORD_BITS-1:0] target_x;
  logic signed [COORD_BITS-1:0] target_y;
  logic signed [COORD_BITS-1:0] target_z;

  modport source (output valid, output target_x, output target_y, output target_z,
                  input ready);
  modport sink   (input valid, input target_x, input target_y, input target_z,
                  output ready);
endinterface

`default_nettype wire

FILE: src/vrt_out_if.sv
// ----------------------------------------------------------------------------
// Traversed voxel channel
// Valid/ready channel carrying one emitted voxel and its flags per transfer.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

interface vrt_out_if #(
  parameter int COORD_BITS = vrt_pkg::COORD_BITS
);
  logic                         valid;
  logic                         ready;
  logic signed [COORD_BITS-1:0] voxel_x;
  logic signed [COORD_BITS-1:0] voxel_y;
  logic signed [COORD_BITS-1:0] voxel_z;
  logic                         last_of_ray;
  logic                         out_of_span;

  modport source (output valid, output voxel_x, output voxel_y, output voxel_z,
                  output last_of_ray, output out_of_span, input ready);
  modport sink   (input valid, input voxel_x, input voxel_y, input voxel_z,
                  input last_of_ray, input out_of_span, output ready);
endinterface

`default_nettype wire

FILE: src/vrt_cfg_if.sv
// ----------------------------------------------------------------------------
// Configuration write channel
// Valid/ready channel carrying a register index and write data per request.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

interface vrt_cfg_if #(
  parameter int DATA_BITS = vrt_pkg::LIMIT_BITS
);
  logic                              valid;
  logic                              ready;
  logic [vrt_pkg::CFG_IDX_BITS-1:0]  index;
  logic [DATA_BITS-1:0]              data;

  modport source (output valid, output index, output data, input ready);
  modport sink   (input valid, input index, input data, output ready);
endinterface

`default_nettype wire

FILE: src/voxel_ray_traversal_3d_top.sv
// One target at a time: a request is taken only in idle, after the last voxel
// of the previous ray went to the output register; output stalls hold the walk.
// A target beyond the span gives a single out-of-span result. Each walk step
// runs the three axes in turn in ST_STEP, then the range compare in ST_EMIT.
// Reset: synchronous, active low; clears the sequencer and output valid, and
// returns the sensor to the origin and the range limit to its maximum.
// ----------------------------------------------------------------------------
// Voxel ray traversal top level
// Walks a 3D Bresenham line from the configured sensor voxel to each target
// and emits every voxel within the squared range limit.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

module voxel_ray_traversal_3d_top #(
  parameter int COORD_BITS = vrt_pkg::COORD_BITS,
  parameter int MAX_SPAN   = vrt_pkg::MAX_SPAN
) (
  input  wire logic  clk,
  input  wire logic  rst_n,
  vrt_in_if.sink     in_if,
  vrt_out_if.source  out_if,
  vrt_cfg_if.sink    cfg_if
);
  import vrt_pkg::*;

  localparam int SPAN_BITS = $clog2(MAX_SPAN + 1);
  localparam int QB        = SPAN_BITS + 1;
  localparam int EB        = SPAN_BITS + 2;
  localparam int ACC_W     = 2 * SPAN_BITS + 2;
  localparam int CMP_W     = (ACC_W > LIMIT_BITS) ? ACC_W : LIMIT_BITS;

  // Configuration registers
  logic signed [COORD_BITS-1:0] sensor_r [3];
  logic [LIMIT_BITS-1:0]        limit_r;

  // Sequencer
  vrt_state_t state_r, state_nxt;
  logic [1:0] ax_r, ax_nxt;

  // Ray datapath
  logic signed [COORD_BITS-1:0] target_r [3], target_nxt [3];
  logic [SPAN_BITS-1:0]         d_r [3], d_nxt [3];
  logic                         dir_r [3], dir_nxt [3];
  logic                         over_r, over_nxt;
  logic [SPAN_BITS-1:0]         dm_r, dm_nxt;
  logic [SPAN_BITS-1:0]         i_r, i_nxt;
  logic signed [EB-1:0]         e_r [3], e_nxt [3];
  logic signed [QB-1:0]         q_r [3], q_nxt [3];
  logic signed [COORD_BITS-1:0] cur_r [3], cur_nxt [3];
  logic [ACC_W-1:0]             acc_r, acc_nxt;

  // Held voxel, released once it is known whether it ends the ray
  logic                         pend_valid_r, pend_valid_nxt;
  logic signed [COORD_BITS-1:0] pend_r [3], pend_nxt [3];
  logic                         pend_oos_r, pend_oos_nxt;

  // Output register
  logic                         out_valid_r, out_valid_nxt;
  logic signed [COORD_BITS-1:0] out_p_r [3], out_p_nxt [3];
  logic                         out_last_r, out_last_nxt;
  logic                         out_oos_r, out_oos_nxt;

  // Axis unit connections
  vrt_flags_t                   unit_flags;
  logic [SPAN_BITS-1:0]         unit_abs;
  logic [2*SPAN_BITS-1:0]       unit_sq;
  logic signed [EB-1:0]         unit_err;
  logic signed [QB-1:0]         unit_off;
  logic signed [COORD_BITS-1:0] unit_voxel;

  logic                 out_free;
  logic                 in_ready;
  logic                 hit;
  logic [SPAN_BITS-1:0] dm_xy;
  logic [SPAN_BITS-1:0] dm_max;

  // Configuration writes; unknown indexes are dropped.
  assign cfg_if.ready = 1'b1;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      sensor_r[0] <= '0;
      sensor_r[1] <= '0;
      sensor_r[2] <= '0;
      limit_r     <= '1;
    end else if (cfg_if.valid) begin
      case (cfg_if.index)
        CFG_SENSOR_X: sensor_r[0] <= cfg_if.data[COORD_BITS-1:0];
        CFG_SENSOR_Y: sensor_r[1] <= cfg_if.data[COORD_BITS-1:0];
        CFG_SENSOR_Z: sensor_r[2] <= cfg_if.data[COORD_BITS-1:0];
        CFG_RANGE_SQ: limit_r     <= cfg_if.data[LIMIT_BITS-1:0];
        default: ;
      endcase
    end
  end

  // Shared axis unit, driven by the current axis selector.
  vrt_axis_unit #(
    .COORD_BITS (COORD_BITS),
    .MAX_SPAN   (MAX_SPAN)
  ) u_axis (
    .sensor     (sensor_r[ax_r]),
    .target     (target_r[ax_r]),
    .flags      (unit_flags),
    .abs_diff   (unit_abs),
    .offset     (q_r[ax_r]),
    .err        (e_r[ax_r]),
    .delta      (d_r[ax_r]),
    .dmax       (dm_r),
    .dir_pos    (dir_r[ax_r]),
    .offset_sq  (unit_sq),
    .err_nxt    (unit_err),
    .offset_nxt (unit_off),
    .voxel      (unit_voxel)
  );

  // Largest axis difference and the range test of the current voxel.
  assign dm_xy    = (d_r[0] > d_r[1]) ? d_r[0] : d_r[1];
  assign dm_max   = (dm_xy > d_r[2]) ? dm_xy : d_r[2];
  assign hit      = CMP_W'(acc_r) <= CMP_W'(limit_r);
  assign out_free = !out_valid_r || out_if.ready;

  // Sequencer state register.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= ST_IDLE;
    end else begin
      state_r <= state_nxt;
    end
  end

  // Next state and datapath control.
  always_comb begin
    state_nxt      = state_r;
    ax_nxt         = ax_r;
    target_nxt     = target_r;
    d_nxt          = d_r;
    dir_nxt        = dir_r;
    over_nxt       = over_r;
    dm_nxt         = dm_r;
    i_nxt          = i_r;
    e_nxt          = e_r;
    q_nxt          = q_r;
    cur_nxt        = cur_r;
    acc_nxt        = acc_r;
    pend_valid_nxt = pend_valid_r;
    pend_nxt       = pend_r;
    pend_oos_nxt   = pend_oos_r;
    out_valid_nxt  = out_valid_r && !out_if.ready;
    out_p_nxt      = out_p_r;
    out_last_nxt   = out_last_r;
    out_oos_nxt    = out_oos_r;
    in_ready       = 1'b0;

    case (state_r)
      ST_IDLE: begin
        in_ready = 1'b1;
        if (in_if.valid) begin
          target_nxt[0] = in_if.target_x;
          target_nxt[1] = in_if.target_y;
          target_nxt[2] = in_if.target_z;
          ax_nxt        = AX_X;
          over_nxt      = 1'b0;
          state_nxt     = ST_SETUP;
        end
      end

      // One axis per cycle: difference, direction and span check.
      ST_SETUP: begin
        d_nxt[ax_r]   = unit_abs;
        dir_nxt[ax_r] = unit_flags.dir_pos;
        over_nxt      = over_r || unit_flags.over;
        if (ax_r == AX_Z) begin
          ax_nxt    = AX_X;
          state_nxt = ST_INIT;
        end else begin
          ax_nxt = ax_r + 2'd1;
        end
      end

      // Start the walk, or queue the single rejected result.
      ST_INIT: begin
        if (over_r) begin
          pend_nxt[0]    = '0;
          pend_nxt[1]    = '0;
          pend_nxt[2]    = '0;
          pend_oos_nxt   = 1'b1;
          pend_valid_nxt = 1'b1;
          state_nxt      = ST_FLUSH;
        end else begin
          dm_nxt         = dm_max;
          i_nxt          = dm_max;
          acc_nxt        = '0;
          pend_oos_nxt   = 1'b0;
          pend_valid_nxt = 1'b0;
          for (int a = 0; a < 3; a++) begin
            e_nxt[a] = {2'b00, (dm_max >> 1)};
            q_nxt[a] = '0;
          end
          state_nxt = ST_STEP;
        end
      end

      // One axis per cycle: accumulate its square, capture it, then advance it.
      ST_STEP: begin
        acc_nxt       = acc_r + {2'b00, unit_sq};
        e_nxt[ax_r]   = unit_err;
        q_nxt[ax_r]   = unit_off;
        cur_nxt[ax_r] = unit_voxel;
        if (ax_r == AX_Z) begin
          ax_nxt    = AX_X;
          state_nxt = ST_EMIT;
        end else begin
          ax_nxt = ax_r + 2'd1;
        end
      end

      // Range compare; a new hit pushes the held voxel to the output.
      ST_EMIT: begin
        if (!(hit && pend_valid_r && !out_free)) begin
          if (hit) begin
            if (pend_valid_r) begin
              out_valid_nxt = 1'b1;
              out_p_nxt     = pend_r;
              out_last_nxt  = 1'b0;
              out_oos_nxt   = 1'b0;
            end
            pend_nxt       = cur_r;
            pend_valid_nxt = 1'b1;
          end
          acc_nxt = '0;
          if (i_r == '0) begin
            state_nxt = ST_FLUSH;
          end else begin
            i_nxt     = i_r - 1'b1;
            state_nxt = ST_STEP;
          end
        end
      end

      // The held voxel is the last of the ray.
      ST_FLUSH: begin
        if (out_free) begin
          out_valid_nxt  = 1'b1;
          out_p_nxt      = pend_r;
          out_last_nxt   = 1'b1;
          out_oos_nxt    = pend_oos_r;
          pend_valid_nxt = 1'b0;
          state_nxt      = ST_IDLE;
        end
      end

      default: begin
        state_nxt = ST_IDLE;
      end
    endcase
  end

  // Control registers.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      ax_r         <= AX_X;
      pend_valid_r <= 1'b0;
      out_valid_r  <= 1'b0;
    end else begin
      ax_r         <= ax_nxt;
      pend_valid_r <= pend_valid_nxt;
      out_valid_r  <= out_valid_nxt;
    end
  end

  // Payload registers.
  always_ff @(posedge clk) begin
    target_r   <= target_nxt;
    d_r        <= d_nxt;
    dir_r      <= dir_nxt;
    over_r     <= over_nxt;
    dm_r       <= dm_nxt;
    i_r        <= i_nxt;
    e_r        <= e_nxt;
    q_r        <= q_nxt;
    cur_r      <= cur_nxt;
    acc_r      <= acc_nxt;
    pend_r     <= pend_nxt;
    pend_oos_r <= pend_oos_nxt;
    out_p_r    <= out_p_nxt;
    out_last_r <= out_last_nxt;
    out_oos_r  <= out_oos_nxt;
  end

  // Channel outputs.
  assign in_if.ready        = in_ready;
  assign out_if.valid       = out_valid_r;
  assign out_if.voxel_x     = out_p_r[0];
  assign out_if.voxel_y     = out_p_r[1];
  assign out_if.voxel_z     = out_p_r[2];
  assign out_if.last_of_ray = out_last_r;
  assign out_if.out_of_span = out_oos_r;

endmodule

`default_nettype wire

FILE: src/vrt_axis_unit.sv
// ----------------------------------------------------------------------------
// Shared axis unit
// Per-axis arithmetic used one axis at a time: absolute difference and
// direction at setup, then square, error update and coordinate step per walk step.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

module vrt_axis_unit #(
  parameter int  COORD_BITS = vrt_pkg::COORD_BITS,
  parameter int  MAX_SPAN   = vrt_pkg::MAX_SPAN,
  localparam int SPAN_BITS  = $clog2(MAX_SPAN + 1),
  localparam int QB         = SPAN_BITS + 1,
  localparam int EB         = SPAN_BITS + 2
) (
  // Setup operands
  input  wire logic signed [COORD_BITS-1:0] sensor,
  input  wire logic signed [COORD_BITS-1:0] target,
  output vrt_pkg::vrt_flags_t               flags,
  output logic [SPAN_BITS-1:0]              abs_diff,
  // Walk operands
  input  wire logic signed [QB-1:0]         offset,
  input  wire logic signed [EB-1:0]         err,
  input  wire logic [SPAN_BITS-1:0]         delta,
  input  wire logic [SPAN_BITS-1:0]         dmax,
  input  wire logic                         dir_pos,
  output logic [2*SPAN_BITS-1:0]            offset_sq,
  output logic signed [EB-1:0]              err_nxt,
  output logic signed [QB-1:0]              offset_nxt,
  output logic signed [COORD_BITS-1:0]      voxel
);
  import vrt_pkg::*;

  localparam int DB = COORD_BITS + 1;
  localparam logic [QB-1:0] Q_ONE = QB'(1);

  logic signed [DB-1:0]   diff;
  logic [DB-1:0]          diff_abs;
  logic signed [2*QB-1:0] sq_full;
  logic signed [EB-1:0]   err_dec;
  logic                   move;

  // Axis difference, one bit wider so it cannot wrap.
  assign diff     = {target[COORD_BITS-1], target} - {sensor[COORD_BITS-1], sensor};
  assign diff_abs = diff[DB-1] ? (~diff + 1'b1) : diff;
  assign abs_diff = diff_abs[SPAN_BITS-1:0];

  assign flags.over    = diff_abs > DB'(MAX_SPAN);
  assign flags.dir_pos = !diff[DB-1] && (diff != '0);

  // Squared offset from the sensor; never exceeds MAX_SPAN squared.
  assign sq_full   = offset * offset;
  assign offset_sq = sq_full[2*SPAN_BITS-1:0];

  // Error term update: step the axis when the error goes negative.
  assign err_dec    = err - {2'b00, delta};
  assign move       = err_dec[EB-1];
  assign err_nxt    = move ? (err_dec + {2'b00, dmax}) : err_dec;
  assign offset_nxt = move ? (dir_pos ? offset + Q_ONE : offset - Q_ONE) : offset;

  // Absolute voxel coordinate, wrapping at the coordinate width.
  assign voxel = sensor + {{(COORD_BITS-QB){offset[QB-1]}}, offset};

endmodule

`default_nettype wire

FILE: src/vrt_checker.sv
// ----------------------------------------------------------------------------
// Voxel ray traversal checker
// Port-level assertions on the traversal block, attached by bind.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

`include "voxel_ray_traversal_3d_top_defines.svh"

module vrt_checker #(
  parameter int COORD_BITS = vrt_pkg::COORD_BITS
) (
  input wire logic                  clk,
  input wire logic                  rst_n,
  input wire logic                  in_valid,
  input wire logic                  in_ready,
  input wire logic                  out_valid,
  input wire logic                  out_ready,
  input wire logic [COORD_BITS-1:0] voxel_x,
  input wire logic [COORD_BITS-1:0] voxel_y,
  input wire logic [COORD_BITS-1:0] voxel_z,
  input wire logic                  last_of_ray,
  input wire logic                  out_of_span
);

  // No result is offered right after a reset edge.
  `VRT_ASSERT_RESET(a_reset_idle, !out_valid)

  // The block works on one target at a time.
  `VRT_ASSERT_NEXT(a_busy_after_request, in_valid && in_ready, !in_ready)

  // A rejected target gives a single zeroed result that ends its ray.
  `VRT_ASSERT_SAME(a_reject_form, out_valid && out_of_span, last_of_ray && voxel_x == '0 && voxel_y == '0 && voxel_z == '0)

  // A stalled result holds its payload.
  `VRT_ASSERT_NEXT(a_out_hold, out_valid && !out_ready, out_valid && $stable(voxel_x) && $stable(voxel_y) && $stable(voxel_z) && $stable(last_of_ray) && $stable(out_of_span))

endmodule

bind voxel_ray_traversal_3d_top vrt_checker #(
  .COORD_BITS (COORD_BITS)
) u_vrt_checker (
  .clk         (clk),
  .rst_n       (rst_n),
  .in_valid    (in_if.valid),
  .in_ready    (in_if.ready),
  .out_valid   (out_if.valid),
  .out_ready   (out_if.ready),
  .voxel_x     (out_if.voxel_x),
  .voxel_y     (out_if.voxel_y),
  .voxel_z     (out_if.voxel_z),
  .last_of_ray (out_if.last_of_ray),
  .out_of_span (out_if.out_of_span)
);

`default_nettype wire
